[design/lkvc_pkg.sv]
// ----------------------------------------------------------------------------
// lkvc_pkg: shared types and constants for the LRU key-value cache
// Holds the cell command codes, the controller states and the structs that
// run along the row of cache cells.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int unsigned LKVC_ENTRIES = 16;
  localparam int unsigned LKVC_DATA_W  = 32;
  localparam int unsigned LKVC_CFG_W   = 5;

  localparam logic [LKVC_CFG_W-1:0] LKVC_CAP_RESET = 5'd16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef enum logic [1:0] {
    CMD_IDLE,
    CMD_TOUCH,
    CMD_EVICT,
    CMD_PLACE
  } cmd_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_UPD
  } state_t;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    cmd_op_t                cmd;
    logic                   wr_value;
    logic [LKVC_DATA_W-1:0] key;
    logic [LKVC_DATA_W-1:0] value;
  } bcast_t;

  // Lookup results gathered cell by cell along the row.
  typedef struct packed {
    logic                   hit;
    logic [LKVC_DATA_W-1:0] value;
    logic [LKVC_DATA_W-1:0] vkey;
  } look_t;

endpackage

[design/lkvc_cell.sv]
// ----------------------------------------------------------------------------
// lkvc_cell: one entry of the LRU key-value cache
// Holds a key, a value, a valid bit and a recency rank. Compares the
// broadcast key, ORs its lookup results into the row, passes the free-slot
// token to its neighbor and applies the broadcast update command.
// ----------------------------------------------------------------------------
module lkvc_cell
  import lkvc_pkg::*;
#(
  parameter int unsigned RANK_W = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  bcast_t                 bcast_i,
  input  logic [RANK_W-1:0]      hit_rank_i,
  input  logic [RANK_W-1:0]      victim_rank_i,
  input  look_t                  chain_i,
  input  logic [RANK_W-1:0]      rank_chain_i,
  input  logic                   free_i,
  output look_t                  chain_o,
  output logic [RANK_W-1:0]      rank_chain_o,
  output logic                   free_o
);

  logic                   valid_r, valid_nxt;
  logic [RANK_W-1:0]      rank_r, rank_nxt;
  logic [LKVC_DATA_W-1:0] key_r, key_nxt;
  logic [LKVC_DATA_W-1:0] value_r, value_nxt;
  logic                   match_r, victim_r;
  logic                   match, victim, take_free;

  assign match     = valid_r && (key_r == bcast_i.key);
  assign victim    = valid_r && (rank_r == victim_rank_i);
  assign take_free = !valid_r && !free_i;
  assign free_o    = free_i || !valid_r;

  assign chain_o.hit   = chain_i.hit | match;
  assign chain_o.value = chain_i.value | (match ? value_r : '0);
  assign chain_o.vkey  = chain_i.vkey | (victim ? key_r : '0);
  assign rank_chain_o  = rank_chain_i | (match ? rank_r : '0);

  always_comb begin
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    case (bcast_i.cmd)
      CMD_TOUCH: begin
        if (match_r) begin
          rank_nxt = '0;
          if (bcast_i.wr_value) begin
            value_nxt = bcast_i.value;
          end
        end else if (valid_r && (rank_r < hit_rank_i)) begin
          rank_nxt = rank_r + 1'b1;
        end
      end
      CMD_EVICT: begin
        if (victim_r) begin
          key_nxt   = bcast_i.key;
          value_nxt = bcast_i.value;
          rank_nxt  = '0;
        end else if (valid_r) begin
          rank_nxt = rank_r + 1'b1;
        end
      end
      CMD_PLACE: begin
        if (take_free) begin
          valid_nxt = 1'b1;
          key_nxt   = bcast_i.key;
          value_nxt = bcast_i.value;
          rank_nxt  = '0;
        end else if (valid_r) begin
          rank_nxt = rank_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      rank_r   <= '0;
      match_r  <= 1'b0;
      victim_r <= 1'b0;
    end else begin
      valid_r  <= valid_nxt;
      rank_r   <= rank_nxt;
      match_r  <= match;
      victim_r <= victim;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

endmodule

[design/lru_key_value_cache.sv]
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key-value cache with LRU replacement
// A request accepted in S_IDLE or S_UPD runs a lookup pass across the cell row
// in S_LOOK, whose results are registered, then an update pass in S_UPD that
// loads the output register. The next request is taken during that update pass;
// a waiting result holds the update pass and the next request.
// Reset: all entries invalid, capacity 16, no result pending.
// ----------------------------------------------------------------------------
module lru_key_value_cache
  import lkvc_pkg::*;
#(
  parameter int unsigned ENTRIES = LKVC_ENTRIES
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [LKVC_CFG_W-1:0]   cfg_wr_data,   // capacity_in_use
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [63:0]             in_tdata,      // [31:0] lookup_key, [63:32] write_value
  input  logic [0:0]              in_tuser,      // [0] opcode
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [63:0]             out_tdata,     // [31:0] read_value, [63:32] evicted_key
  output logic [1:0]              out_tuser      // [0] hit, [1] evicted
);

  localparam int unsigned RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W  = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W  = (CNT_W > LKVC_CFG_W) ? CNT_W : LKVC_CFG_W;

  state_t                 state_r, state_nxt;
  logic [LKVC_CFG_W-1:0]  cap_r;
  logic [CNT_W-1:0]       count_r;
  logic                   req_op_r;
  logic [LKVC_DATA_W-1:0] req_key_r, req_value_r;
  logic                   hit_r;
  logic [RANK_W-1:0]      hit_rank_r;
  logic [LKVC_DATA_W-1:0] hit_value_r, vkey_r;
  logic                   out_valid_r, out_hit_r, out_ev_r;
  logic [LKVC_DATA_W-1:0] out_rd_r, out_evk_r;

  logic                   out_free, upd_go, accept, full;
  logic [CMP_W-1:0]       cap_ext, cap_eff;
  logic [RANK_W-1:0]      victim_rank;
  bcast_t                 bcast;

  look_t                  chain      [0:ENTRIES];
  logic [RANK_W-1:0]      rank_chain [0:ENTRIES];
  logic [ENTRIES:0]       free_chain;

  assign out_free = !out_valid_r || out_tready;
  assign accept   = in_tvalid && in_tready;

  // Capacity zero acts as one; above the store size it acts as the size.
  assign cap_ext = CMP_W'(cap_r);
  assign cap_eff = (cap_ext == '0) ? CMP_W'(1) :
                   ((cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext);
  assign full    = CMP_W'(count_r) >= cap_eff;

  // Valid ranks form 0..count-1, so the least recent entry has rank count-1.
  assign victim_rank = RANK_W'(count_r - 1'b1);

  always_comb begin
    state_nxt      = state_r;
    upd_go         = 1'b0;
    in_tready      = 1'b0;
    bcast.cmd      = CMD_IDLE;
    bcast.wr_value = 1'b0;
    bcast.key      = req_key_r;
    bcast.value    = req_value_r;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (out_free) begin
          upd_go    = 1'b1;
          in_tready = 1'b1;
          state_nxt = in_tvalid ? S_LOOK : S_IDLE;
          if (hit_r) begin
            bcast.cmd      = CMD_TOUCH;
            bcast.wr_value = (req_op_r == OP_PUT);
          end else if (req_op_r == OP_PUT) begin
            bcast.cmd = full ? CMD_EVICT : CMD_PLACE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign chain[0]      = '0;
  assign rank_chain[0] = '0;
  assign free_chain[0] = 1'b0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lkvc_cell #(
      .RANK_W (RANK_W)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .bcast_i       (bcast),
      .hit_rank_i    (hit_rank_r),
      .victim_rank_i (victim_rank),
      .chain_i       (chain[i]),
      .rank_chain_i  (rank_chain[i]),
      .free_i        (free_chain[i]),
      .chain_o       (chain[i+1]),
      .rank_chain_o  (rank_chain[i+1]),
      .free_o        (free_chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= LKVC_CAP_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (upd_go && (bcast.cmd == CMD_PLACE)) begin
        count_r <= count_r + 1'b1;
      end
      if (upd_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_op_r    <= in_tuser[0];
      req_key_r   <= in_tdata[31:0];
      req_value_r <= in_tdata[63:32];
    end
    if (state_r == S_LOOK) begin
      hit_r       <= chain[ENTRIES].hit;
      hit_value_r <= chain[ENTRIES].value;
      vkey_r      <= chain[ENTRIES].vkey;
      hit_rank_r  <= rank_chain[ENTRIES];
    end
    if (upd_go) begin
      out_hit_r <= hit_r;
      out_ev_r  <= (bcast.cmd == CMD_EVICT);
      out_evk_r <= (bcast.cmd == CMD_EVICT) ? vkey_r : '0;
      if (req_op_r == OP_GET) begin
        out_rd_r <= hit_r ? hit_value_r : '1;
      end else begin
        out_rd_r <= '0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_evk_r, out_rd_r};
  assign out_tuser  = {out_ev_r, out_hit_r};

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(ENTRIES))
    else $error("entry count exceeds the store size");

  a_full_no_free: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == CNT_W'(ENTRIES)) == !free_chain[ENTRIES])
    else $error("entry count disagrees with the free slot chain");

  a_place_has_free: assert property (@(posedge clk) disable iff (!rst_n)
    (upd_go && (bcast.cmd == CMD_PLACE)) |-> free_chain[ENTRIES])
    else $error("new entry placed with no free slot");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    upd_go |=> out_valid_r)
    else $error("update pass gave no result");
`endif

endmodule
